// ----- rtl/tfcm_pkg.sv -----
// ----------------------------------------------------------------------------
// tfcm_pkg: shared types, constants and palette tables
// Widths, register indexes, palette codes and the fixed color tables used by
// the thermal false-color mapper.
// ----------------------------------------------------------------------------
package tfcm_pkg;

  localparam int TEMP_BITS = 16;
  localparam int FRAC_BITS = 16;

  // config port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TEMP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TEMP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE = 2'd2;

  localparam logic [TEMP_BITS-1:0] LOW_TEMP_RST  = TEMP_BITS'(0);
  localparam logic [TEMP_BITS-1:0] HIGH_TEMP_RST = TEMP_BITS'(1600);

  // palette_mode codes
  localparam int PAL_W = 3;
  typedef logic [PAL_W-1:0] mode_t;
  localparam mode_t PAL_VIVID   = 3'd0;
  localparam mode_t PAL_RGB     = 3'd1;
  localparam mode_t PAL_GRAY    = 3'd2;
  localparam mode_t PAL_MEDICAL = 3'd3;
  localparam mode_t PAL_IRON    = 3'd4;
  localparam mode_t PAL_FIRE    = 3'd5;
  localparam mode_t PAL_OCEAN   = 3'd6;
  localparam mode_t PAL_RST     = PAL_VIVID;

  // color table selectors
  typedef logic [2:0] tpal_t;
  localparam tpal_t TPAL_VIVID   = 3'd0;
  localparam tpal_t TPAL_MEDICAL = 3'd1;
  localparam tpal_t TPAL_IRON    = 3'd2;
  localparam tpal_t TPAL_FIRE    = 3'd3;
  localparam tpal_t TPAL_OCEAN   = 3'd4;

  // pixel class decided in the front end
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_ZERO = 2'd0;
  localparam cls_t CLS_ONE  = 2'd1;
  localparam cls_t CLS_DIV  = 2'd2;

  // normalized fraction, Q0.FRAC_BITS with one.0 representable
  localparam int F_W = FRAC_BITS + 1;
  localparam logic [F_W-1:0] ONE_FRAC = F_W'(1) << FRAC_BITS;

  // interpolation product: (FRAC_BITS+1)-bit fraction times 9-bit delta
  localparam int PROD_W = FRAC_BITS + 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // [2] red, [1] green, [0] blue
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    cls_t                 cls;
    logic [TEMP_BITS-1:0] rem;   // temperature - low_temp
    logic [TEMP_BITS-1:0] den;   // high_temp - low_temp
    mode_t                mode;
  } q_entry_t;

  function automatic tpal_t tpal_of(input mode_t mode);
    tpal_t t;
    t = TPAL_VIVID;
    case (mode)
      PAL_MEDICAL: t = TPAL_MEDICAL;
      PAL_IRON:    t = TPAL_IRON;
      PAL_FIRE:    t = TPAL_FIRE;
      PAL_OCEAN:   t = TPAL_OCEAN;
      default:     t = TPAL_VIVID;
    endcase
    return t;
  endfunction

  // index of the last color of a table
  function automatic logic [2:0] last_idx(input tpal_t tpal);
    logic [2:0] n;
    n = 3'd7;
    case (tpal)
      TPAL_VIVID: n = 3'd5;
      TPAL_FIRE:  n = 3'd6;
      default:    n = 3'd7;
    endcase
    return n;
  endfunction

  function automatic rgb_t color_lut(input tpal_t tpal, input logic [2:0] idx);
    rgb_t c;
    c = '0;
    case (tpal)
      TPAL_VIVID: begin
        case (idx)
          3'd0:    c = {8'd0,   8'd0,   8'd255};
          3'd1:    c = {8'd0,   8'd255, 8'd255};
          3'd2:    c = {8'd0,   8'd255, 8'd0};
          3'd3:    c = {8'd255, 8'd255, 8'd0};
          3'd4:    c = {8'd255, 8'd0,   8'd0};
          3'd5:    c = {8'd255, 8'd0,   8'd255};
          default: c = {8'd0,   8'd0,   8'd0};
        endcase
      end
      TPAL_MEDICAL: begin
        case (idx)
          3'd0:    c = {8'd0,   8'd0,   8'd0};
          3'd1:    c = {8'd0,   8'd0,   8'd128};
          3'd2:    c = {8'd0,   8'd128, 8'd255};
          3'd3:    c = {8'd0,   8'd255, 8'd128};
          3'd4:    c = {8'd128, 8'd255, 8'd0};
          3'd5:    c = {8'd255, 8'd128, 8'd0};
          3'd6:    c = {8'd255, 8'd0,   8'd0};
          default: c = {8'd255, 8'd255, 8'd255};
        endcase
      end
      TPAL_IRON: begin
        case (idx)
          3'd0:    c = {8'd0,   8'd0,   8'd0};
          3'd1:    c = {8'd32,  8'd0,   8'd0};
          3'd2:    c = {8'd128, 8'd0,   8'd0};
          3'd3:    c = {8'd255, 8'd64,  8'd0};
          3'd4:    c = {8'd255, 8'd128, 8'd0};
          3'd5:    c = {8'd255, 8'd192, 8'd0};
          3'd6:    c = {8'd255, 8'd255, 8'd128};
          default: c = {8'd255, 8'd255, 8'd255};
        endcase
      end
      TPAL_FIRE: begin
        case (idx)
          3'd0:    c = {8'd0,   8'd0,   8'd0};
          3'd1:    c = {8'd64,  8'd0,   8'd0};
          3'd2:    c = {8'd255, 8'd0,   8'd0};
          3'd3:    c = {8'd255, 8'd128, 8'd0};
          3'd4:    c = {8'd255, 8'd255, 8'd0};
          3'd5:    c = {8'd255, 8'd255, 8'd128};
          3'd6:    c = {8'd255, 8'd255, 8'd255};
          default: c = {8'd0,   8'd0,   8'd0};
        endcase
      end
      TPAL_OCEAN: begin
        case (idx)
          3'd0:    c = {8'd0,   8'd0,   8'd0};
          3'd1:    c = {8'd0,   8'd0,   8'd32};
          3'd2:    c = {8'd0,   8'd0,   8'd128};
          3'd3:    c = {8'd0,   8'd128, 8'd255};
          3'd4:    c = {8'd0,   8'd192, 8'd255};
          3'd5:    c = {8'd128, 8'd255, 8'd255};
          3'd6:    c = {8'd192, 8'd255, 8'd255};
          default: c = {8'd255, 8'd255, 8'd255};
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/tfcm_front.sv -----
// ----------------------------------------------------------------------------
// tfcm_front: config registers and pixel classification
// Takes a pixel beat, compares it against the configured range and hands the
// classified work item to the queue.
// ----------------------------------------------------------------------------
module tfcm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [tfcm_pkg::TEMP_BITS-1:0]      in_temperature,
  input  logic                                cfg_we,
  input  logic [tfcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfcm_pkg::TEMP_BITS-1:0]      cfg_data,
  input  logic                                q_full,
  output logic                                busy,
  output logic                                push,
  output tfcm_pkg::q_entry_t                  push_entry
);
  import tfcm_pkg::*;

  logic [TEMP_BITS-1:0] low_r;
  logic [TEMP_BITS-1:0] high_r;
  mode_t                mode_r;

  logic [TEMP_BITS:0]   diff_w;
  logic [TEMP_BITS:0]   span_w;
  logic                 empty_w;
  logic                 below_w;
  logic                 above_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_TEMP_RST;
      high_r <= HIGH_TEMP_RST;
      mode_r <= PAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_TEMP:     low_r  <= cfg_data;
        CFG_HIGH_TEMP:    high_r <= cfg_data;
        CFG_PALETTE_MODE: mode_r <= cfg_data[PAL_W-1:0];
        default:          ;
      endcase
    end
  end

  assign diff_w  = {in_temperature[TEMP_BITS-1], in_temperature} - {low_r[TEMP_BITS-1], low_r};
  assign span_w  = {high_r[TEMP_BITS-1], high_r} - {low_r[TEMP_BITS-1], low_r};
  assign empty_w = $signed(high_r) <= $signed(low_r);
  assign below_w = $signed(in_temperature) <= $signed(low_r);
  assign above_w = $signed(in_temperature) >= $signed(high_r);

  assign busy = q_full || !rst_n;
  assign push = start && !busy;

  always_comb begin
    push_entry.rem  = diff_w[TEMP_BITS-1:0];
    push_entry.den  = span_w[TEMP_BITS-1:0];
    push_entry.mode = mode_r;
    if (empty_w || below_w) begin
      push_entry.cls = CLS_ZERO;
    end else if (above_w) begin
      push_entry.cls = CLS_ONE;
    end else begin
      push_entry.cls = CLS_DIV;
    end
  end

endmodule

// ----- rtl/tfcm_queue.sv -----
// ----------------------------------------------------------------------------
// tfcm_queue: short work queue between front end and back end
// Small register FIFO; head is visible while not empty.
// ----------------------------------------------------------------------------
module tfcm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tfcm_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output tfcm_pkg::q_entry_t head_entry
);
  import tfcm_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/tfcm_div.sv -----
// ----------------------------------------------------------------------------
// tfcm_div: pipelined restoring divider for the normalization
// One quotient bit per stage, FRAC_BITS stages; gives the Q0.FRAC_BITS fraction.
// ----------------------------------------------------------------------------
module tfcm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  tfcm_pkg::q_entry_t            in_entry,
  output logic                          f_valid,
  output logic [tfcm_pkg::F_W-1:0]      f_value,
  output tfcm_pkg::mode_t               f_mode
);
  import tfcm_pkg::*;

  localparam int NS = FRAC_BITS;

  logic                 vld_r  [NS];
  cls_t                 cls_r  [NS];
  logic [TEMP_BITS-1:0] rem_r  [NS];
  logic [TEMP_BITS-1:0] den_r  [NS];
  logic [FRAC_BITS-1:0] quo_r  [NS];
  mode_t                mode_r [NS];

  logic                 src_v    [NS];
  cls_t                 src_cls  [NS];
  logic [TEMP_BITS-1:0] src_rem  [NS];
  logic [TEMP_BITS-1:0] src_den  [NS];
  logic [FRAC_BITS-1:0] src_quo  [NS];
  mode_t                src_mode [NS];

  logic [TEMP_BITS:0]   shl_w   [NS];
  logic [TEMP_BITS:0]   sub_w   [NS];
  logic                 ge_w    [NS];
  logic [TEMP_BITS-1:0] rem_nxt [NS];
  logic [FRAC_BITS-1:0] quo_nxt [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign src_v[j]    = in_valid;
      assign src_cls[j]  = in_entry.cls;
      assign src_rem[j]  = in_entry.rem;
      assign src_den[j]  = in_entry.den;
      assign src_quo[j]  = '0;
      assign src_mode[j] = in_entry.mode;
    end else begin : g_next
      assign src_v[j]    = vld_r[j-1];
      assign src_cls[j]  = cls_r[j-1];
      assign src_rem[j]  = rem_r[j-1];
      assign src_den[j]  = den_r[j-1];
      assign src_quo[j]  = quo_r[j-1];
      assign src_mode[j] = mode_r[j-1];
    end

    // rem < den holds on every stage, so the shifted value fits TEMP_BITS+1
    assign shl_w[j]   = {src_rem[j], 1'b0};
    assign sub_w[j]   = shl_w[j] - {1'b0, src_den[j]};
    assign ge_w[j]    = shl_w[j] >= {1'b0, src_den[j]};
    assign rem_nxt[j] = ge_w[j] ? sub_w[j][TEMP_BITS-1:0] : shl_w[j][TEMP_BITS-1:0];
    assign quo_nxt[j] = {src_quo[j][FRAC_BITS-2:0], ge_w[j]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= src_v[j];
      end
    end

    always_ff @(posedge clk) begin
      cls_r[j]  <= src_cls[j];
      rem_r[j]  <= rem_nxt[j];
      den_r[j]  <= src_den[j];
      quo_r[j]  <= quo_nxt[j];
      mode_r[j] <= src_mode[j];
    end
  end

  assign f_valid = vld_r[NS-1];
  assign f_mode  = mode_r[NS-1];

  always_comb begin
    case (cls_r[NS-1])
      CLS_ONE: f_value = ONE_FRAC;
      CLS_DIV: f_value = {1'b0, quo_r[NS-1]};
      default: f_value = '0;
    endcase
  end

endmodule

// ----- rtl/tfcm_color.sv -----
// ----------------------------------------------------------------------------
// tfcm_color: palette mapping back end
// Three stages: table index and ramp segment, table read and products,
// final add and palette select into the output register.
// ----------------------------------------------------------------------------
module tfcm_color (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     f_valid,
  input  logic [tfcm_pkg::F_W-1:0] f_value,
  input  tfcm_pkg::mode_t          f_mode,
  output logic                     out_valid,
  output tfcm_pkg::rgb_t           out_rgb
);
  import tfcm_pkg::*;

  localparam int X_W = FRAC_BITS - 1;
  localparam logic [X_W-1:0] RAMP_Q = X_W'(1) << (FRAC_BITS - 2);
  localparam logic [FRAC_BITS+8:0] GRAY_HALF = (FRAC_BITS + 9)'(1) << (FRAC_BITS - 1);

  // ramp segments
  localparam logic [1:0] SEG_GREEN_UP  = 2'd0;
  localparam logic [1:0] SEG_BLUE_DOWN = 2'd1;
  localparam logic [1:0] SEG_RED_UP    = 2'd2;
  localparam logic [1:0] SEG_BLUE_UP   = 2'd3;

  // ---- stage 1 ----
  tpal_t                tpal_c;
  logic [2:0]           nm1_c;
  logic [FRAC_BITS+2:0] s_c;
  logic [1:0]           k_c;
  logic [X_W-1:0]       l_c;
  logic [X_W-1:0]       x_c;

  logic                 v1_r;
  mode_t                mode1_r;
  tpal_t                tpal1_r;
  logic [2:0]           idx1_r;
  logic [FRAC_BITS-1:0] p1_r;
  logic                 last1_r;
  logic [1:0]           k1_r;
  logic [X_W-1:0]       x1_r;
  logic [F_W-1:0]       f1_r;

  assign tpal_c = tpal_of(f_mode);
  assign nm1_c  = last_idx(tpal_c);
  assign s_c    = (FRAC_BITS + 3)'(f_value) * (FRAC_BITS + 3)'(nm1_c);

  always_comb begin
    if (f_value[FRAC_BITS]) begin
      k_c = SEG_BLUE_UP;
      l_c = RAMP_Q;
    end else begin
      k_c = f_value[FRAC_BITS-1:FRAC_BITS-2];
      l_c = {1'b0, f_value[FRAC_BITS-3:0]};
    end
    x_c = (k_c == SEG_BLUE_DOWN) ? RAMP_Q - l_c : l_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= f_mode;
    tpal1_r <= tpal_c;
    idx1_r  <= s_c[FRAC_BITS+2:FRAC_BITS];
    p1_r    <= s_c[FRAC_BITS-1:0];
    last1_r <= s_c[FRAC_BITS+2:FRAC_BITS] >= nm1_c;
    k1_r    <= k_c;
    x1_r    <= x_c;
    f1_r    <= f_value;
  end

  // ---- stage 2 ----
  rgb_t                  c1_c;
  rgb_t                  c2_c;
  logic signed [8:0]     d_c    [3];
  logic signed [PROD_W-1:0] prod_c [3];
  logic [FRAC_BITS+6:0]  ramp_full_c;
  logic [FRAC_BITS+8:0]  gray_full_c;

  logic                  v2_r;
  mode_t                 mode2_r;
  logic [1:0]            k2_r;
  rgb_t                  c1_2_r;
  logic [PROD_W-1:0]     prod2_r [3];
  logic [7:0]            ramp2_r;
  logic [7:0]            gray2_r;

  always_comb begin
    c1_c = color_lut(tpal1_r, last1_r ? last_idx(tpal1_r) : idx1_r);
    c2_c = last1_r ? c1_c : color_lut(tpal1_r, idx1_r + 3'd1);
    for (int ch = 0; ch < 3; ch++) begin
      d_c[ch]    = $signed({1'b0, c2_c[ch]}) - $signed({1'b0, c1_c[ch]});
      prod_c[ch] = PROD_W'($signed({1'b0, p1_r})) * PROD_W'(d_c[ch]);
    end
    ramp_full_c = {x1_r, 8'b0} - {8'b0, x1_r};
    gray_full_c = {f1_r, 8'b0} - {8'b0, f1_r} + GRAY_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mode2_r <= mode1_r;
    k2_r    <= k1_r;
    c1_2_r  <= c1_c;
    for (int ch = 0; ch < 3; ch++) begin
      prod2_r[ch] <= prod_c[ch];
    end
    ramp2_r <= ramp_full_c[FRAC_BITS+5:FRAC_BITS-2];
    gray2_r <= gray_full_c[FRAC_BITS+7:FRAC_BITS];
  end

  // ---- stage 3 ----
  logic [PROD_W-1:0] acc_c [3];
  rgb_t              tab_c;
  rgb_t              ramp_c;
  rgb_t              rgb_nxt;
  logic              out_valid_r;
  rgb_t              out_rgb_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc_c[ch] = {2'b00, c1_2_r[ch], {FRAC_BITS{1'b0}}} + prod2_r[ch];
      tab_c[ch] = acc_c[ch][FRAC_BITS+7:FRAC_BITS];
    end
    case (k2_r)
      SEG_GREEN_UP:  ramp_c = {8'd0,    ramp2_r, 8'd255};
      SEG_BLUE_DOWN: ramp_c = {8'd0,    8'd255,  ramp2_r};
      SEG_RED_UP:    ramp_c = {ramp2_r, 8'd255,  8'd0};
      default:       ramp_c = {8'd255,  8'd255,  ramp2_r};
    endcase
    case (mode2_r) inside
      PAL_VIVID, PAL_MEDICAL, PAL_IRON, PAL_FIRE, PAL_OCEAN: rgb_nxt = tab_c;
      PAL_RGB:  rgb_nxt = ramp_c;
      PAL_GRAY: rgb_nxt = {gray2_r, gray2_r, gray2_r};
      default:  rgb_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_rgb_r <= rgb_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rgb   = out_rgb_r;

endmodule

// ----- rtl/thermal_false_color_mapper.sv -----
// ----------------------------------------------------------------------------
// thermal_false_color_mapper: temperature pixel to false-color RGB
// Normalizes a Q12.4 pixel against a configured range and maps it through a
// selectable palette.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a pixel beat is taken at a clock edge with start high and busy low;
//   in_temperature is signed Q12.4 Celsius. One pixel per clock is sustained.
//   Output: every pixel gives exactly one beat on out_red/out_green/out_blue,
//   flagged by out_valid for one cycle, in input order. The receiver has no
//   hold-off; results must be taken as they appear.
//   Path: an accepted pixel passes through the queue register, the FRAC_BITS
//   divider stages (one quotient bit per stage) and the three color stages
//   before its result beat appears.
//   Throughput: one pixel per clock while busy is low.
//   busy: high during reset and when the work queue is full; since the back end
//   drains the queue every cycle, it stays low in operation.
//   Config: cfg_we/cfg_index/cfg_data write low_temp (0), high_temp (1) and
//   palette_mode (2); other indexes are ignored. Write only while
//   no pixel is in flight.
//   Reset (synchronous, rst_n low): drops all pixels in flight and restores
//   low_temp 0, high_temp 100.0 C, palette vivid.
// ----------------------------------------------------------------------------
module thermal_false_color_mapper (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tfcm_pkg::TEMP_BITS-1:0]     in_temperature,
  output logic                               out_valid,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  input  logic                               cfg_we,
  input  logic [tfcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfcm_pkg::TEMP_BITS-1:0]     cfg_data
);
  import tfcm_pkg::*;

  localparam int LAT = FRAC_BITS + 4;

  logic           q_full;
  logic           push;
  q_entry_t       push_entry;
  logic           head_valid;
  q_entry_t       head_entry;
  logic           f_valid;
  logic [F_W-1:0] f_value;
  mode_t          f_mode;
  rgb_t           rgb;

  // front end: config and classification
  tfcm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_temperature (in_temperature),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .busy           (busy),
    .push           (push),
    .push_entry     (push_entry)
  );

  // queue decouples the two halves; the back end pops whenever data is there
  tfcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (head_valid),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // back end: divider then palette mapping
  tfcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (head_valid),
    .in_entry (head_entry),
    .f_valid  (f_valid),
    .f_value  (f_value),
    .f_mode   (f_mode)
  );

  tfcm_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .f_valid   (f_valid),
    .f_value   (f_value),
    .f_mode    (f_mode),
    .out_valid (out_valid),
    .out_rgb   (rgb)
  );

  assign out_red   = rgb[2];
  assign out_green = rgb[1];
  assign out_blue  = rgb[0];

`ifndef ASSERT_OFF
  // every accepted pixel produces a beat a fixed time later
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted pixel did not produce a result beat");

  // no beat without a pixel accepted at the matching edge
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without a matching accepted pixel");

  // back end drains every cycle, so the queue never fills
  a_queue_never_full: assert property (@(posedge clk) disable iff (!rst_n)
    !q_full)
    else $error("work queue filled up");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for thermal_false_color_mapper
// Drives Q12.4 pixels through the start/busy port and compares every color
// beat on the strobe port with a typed-in color or a behavioral color
// predictor. A short table of directed rows is followed by random phases
// that each set a fresh range and palette.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfcm_pkg::*;

  // Accept edge to result edge; used only for the settle time at the end.
  localparam int LATENCY = FRAC_BITS + 4;
  localparam longint UNIT = longint'(1) << FRAC_BITS;  // fraction 1.0
  localparam int N_DIRECTED = 40;
  localparam int PHASES = 16;
  localparam int BEATS_PER_PHASE = 75;

  // Codes the package leaves unnamed: the unused palette and the spare index.
  localparam mode_t PAL_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Palette colors as {red, green, blue}, eight slots per palette in the
  // order vivid, medical, iron, fire, ocean.
  localparam logic [0:39][23:0] PALETTES = {
    24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00,
    24'hFF0000, 24'hFF00FF, 24'h000000, 24'h000000,
    24'h000000, 24'h000080, 24'h0080FF, 24'h00FF80,
    24'h80FF00, 24'hFF8000, 24'hFF0000, 24'hFFFFFF,
    24'h000000, 24'h200000, 24'h800000, 24'hFF4000,
    24'hFF8000, 24'hFFC000, 24'hFFFF80, 24'hFFFFFF,
    24'h000000, 24'h400000, 24'hFF0000, 24'hFF8000,
    24'hFFFF00, 24'hFFFF80, 24'hFFFFFF, 24'h000000,
    24'h000000, 24'h000020, 24'h000080, 24'h0080FF,
    24'h00C0FF, 24'h80FFFF, 24'hC0FFFF, 24'hFFFFFF
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // One directed row: either a register write or a pixel beat, the latter
  // optionally with its color typed in.
  typedef struct packed {
    logic                 wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [TEMP_BITS-1:0] value;   // register data or pixel temperature
    logic                 known;
    color_t               rgb;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [TEMP_BITS-1:0] in_temperature = '0;
  logic                 out_valid;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TEMP_BITS-1:0] cfg_data = '0;

  // Shadow of the register file, updated at the edge that takes a write.
  logic signed [TEMP_BITS-1:0] lo_bound;
  logic signed [TEMP_BITS-1:0] hi_bound;
  mode_t                       palette_sel;

  color_t pending_colors[$];   // colors owed by the block, oldest first
  color_t wanted;
  int     mismatches = 0;

  thermal_false_color_mapper DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_temperature (in_temperature),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Color predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] ramp255(input longint x);
    return 8'((x * 255) >> (FRAC_BITS - 2));
  endfunction

  function automatic color_t false_color(input logic signed [TEMP_BITS-1:0] t);
    longint span, frac, s, p, k, l, c1, c2;
    int tab, last, idx;
    logic [23:0] rgb, ca, cb;
    rgb = '0;
    tab = 0;
    last = 0;
    // Normalize to Q0.FRAC_BITS; an empty or reversed range pins it to zero.
    span = longint'(hi_bound) - longint'(lo_bound);
    if (span <= 0 || t <= lo_bound) frac = 0;
    else if (t >= hi_bound) frac = UNIT;
    else frac = ((longint'(t) - longint'(lo_bound)) << FRAC_BITS) / span;

    case (palette_sel)
      PAL_RGB: begin
        // four quarter segments; 1.0 lands at the end of the last one
        k = frac >> (FRAC_BITS - 2);
        if (k > 3) k = 3;
        l = frac - k * (UNIT / 4);
        case (k)
          0: rgb = {8'd0, ramp255(l), 8'd255};
          1: rgb = {8'd0, 8'd255, ramp255(UNIT / 4 - l)};
          2: rgb = {ramp255(l), 8'd255, 8'd0};
          default: rgb = {8'd255, 8'd255, ramp255(l)};
        endcase
      end
      PAL_GRAY: rgb = {3{8'((frac * 255 + UNIT / 2) >> FRAC_BITS)}};
      PAL_VIVID, PAL_MEDICAL, PAL_IRON, PAL_FIRE, PAL_OCEAN: begin
        case (palette_sel)
          PAL_MEDICAL: begin tab = 1; last = 7; end
          PAL_IRON:    begin tab = 2; last = 7; end
          PAL_FIRE:    begin tab = 3; last = 6; end
          PAL_OCEAN:   begin tab = 4; last = 7; end
          default:     begin tab = 0; last = 5; end
        endcase
        s = frac * last;
        idx = int'(s >> FRAC_BITS);
        p = s & (UNIT - 1);
        if (idx >= last) begin
          rgb = PALETTES[tab * 8 + last];
        end else begin
          ca = PALETTES[tab * 8 + idx];
          cb = PALETTES[tab * 8 + idx + 1];
          // truncating linear blend, per channel
          for (int ch = 0; ch < 3; ch++) begin
            c1 = ca[8 * ch +: 8];
            c2 = cb[8 * ch +: 8];
            rgb[8 * ch +: 8] = 8'((c1 * UNIT + p * (c2 - c1)) >> FRAC_BITS);
          end
        end
      end
      default: rgb = '0;   // unused palette code gives black
    endcase
    return rgb;
  endfunction

  // --------------------------------------------------------------------------
  // Directed row builders
  // --------------------------------------------------------------------------
  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [TEMP_BITS-1:0] data);
    step_t r;
    r = '0;
    r.wr = 1'b1;
    r.idx = idx;
    r.value = data;
    return r;
  endfunction

  function automatic step_t pixel_row(input int t);
    step_t r;
    r = '0;
    r.value = TEMP_BITS'(t);
    return r;
  endfunction

  function automatic step_t known_row(input int t, input logic [23:0] rgb);
    step_t r;
    r = pixel_row(t);
    r.known = 1'b1;
    r.rgb = rgb;
    return r;
  endfunction

  function automatic logic [TEMP_BITS-1:0] clamp_temp(input int v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7FFF;
    return TEMP_BITS'(v);
  endfunction

  // Random pixel: mostly inside the configured range with some overshoot,
  // plus exact bounds, their neighbors and fully random codes.
  function automatic logic [TEMP_BITS-1:0] pick_temperature();
    int lo, hi, margin, kind;
    lo = lo_bound;
    hi = hi_bound;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return TEMP_BITS'($urandom);
      1: return lo_bound;
      2: return hi_bound;
      3: return clamp_temp(lo + int'($urandom_range(0, 2)) - 1);
      4: return clamp_temp(hi + int'($urandom_range(0, 2)) - 1);
      default: begin
        if (hi <= lo) return clamp_temp(lo + int'($urandom_range(0, 64)) - 32);
        margin = (hi - lo) / 8;
        return clamp_temp(lo - margin + int'($urandom_range(0, hi - lo + 2 * margin)));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers: inputs move on the falling edge, handshakes are read on the
  // rising edge.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [TEMP_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_LOW_TEMP:     lo_bound = data;
      CFG_HIGH_TEMP:    hi_bound = data;
      CFG_PALETTE_MODE: palette_sel = data[PAL_W-1:0];
      default: ;        // spare index, nothing changes
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel beat and hold it until the block takes it.
  task automatic send_pixel(input logic [TEMP_BITS-1:0] t, input logic known,
                            input color_t rgb);
    @(negedge clk);
    start <= 1'b1;
    in_temperature <= t;
    do @(posedge clk); while (busy);
    pending_colors.push_back(known ? rgb : false_color(t));
  endtask

  // Sender gap: usually none, often a short one, now and then a long one.
  task automatic idle_gap();
    int pick, n;
    pick = $urandom_range(0, 99);
    if (pick < 60) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else if (pick < 98) n = $urandom_range(4, 20);
    else n = $urandom_range(30, 80);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_temperature <= TEMP_BITS'($urandom);   // junk while idle
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every owed color has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
  endtask

  // New range and palette for a random phase. The palette walks through all
  // eight codes; bits above the mode field carry junk.
  task automatic configure_phase(input int phase);
    int lo, span, kind;
    logic [TEMP_BITS-1:0] data;
    kind = $urandom_range(0, 9);
    lo = int'($urandom_range(0, 65535)) - 32768;
    case (kind)
      0: begin
        write_reg(CFG_LOW_TEMP, TEMP_BITS'($urandom));
        write_reg(CFG_HIGH_TEMP, TEMP_BITS'($urandom));
      end
      1: begin
        write_reg(CFG_LOW_TEMP, 16'h8000);
        write_reg(CFG_HIGH_TEMP, 16'h7FFF);
      end
      2: begin   // empty range: high at or below low
        write_reg(CFG_LOW_TEMP, clamp_temp(lo));
        write_reg(CFG_HIGH_TEMP, clamp_temp(lo - int'($urandom_range(0, 100))));
      end
      default: begin
        span = (kind < 6) ? $urandom_range(1, 64) : $urandom_range(65, 8000);
        write_reg(CFG_LOW_TEMP, clamp_temp(lo));
        write_reg(CFG_HIGH_TEMP, clamp_temp(lo + span));
      end
    endcase
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, TEMP_BITS'($urandom));
    data = TEMP_BITS'($urandom);
    data[PAL_W-1:0] = mode_t'(phase % 8);
    write_reg(CFG_PALETTE_MODE, data);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every strobed beat must match the oldest owed color.
  // --------------------------------------------------------------------------
  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %0d/%0d/%0d",
                 $time, out_red, out_green, out_blue);
        mismatches++;
      end else begin
        wanted = pending_colors.pop_front();
        check_channel("red", wanted.red, out_red);
        check_channel("green", wanted.green, out_green);
        check_channel("blue", wanted.blue, out_blue);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    step_t plan [N_DIRECTED];
    bit    steady;

    // reset state: range 0.0 .. 100.0 C, vivid palette
    lo_bound = '0;
    hi_bound = 16'sd1600;
    palette_sel = PAL_VIVID;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows. Colors are typed in where they fall straight out of the
    // palette ends; the rest go through the predictor.
    plan = '{
      known_row(0, 24'h0000FF),          // reset range, bottom of vivid
      known_row(1600, 24'hFF00FF),       // exactly at the high bound
      known_row(-32768, 24'h0000FF),     // most negative pixel clamps to 0
      known_row(32767, 24'hFF00FF),      // most positive pixel clamps to 1
      pixel_row(800),
      reg_row(CFG_PALETTE_MODE, TEMP_BITS'(PAL_RGB)),
      known_row(1600, 24'hFFFFFF),       // 1.0 ends the last ramp segment
      known_row(0, 24'h0000FF),
      pixel_row(400),                    // segment boundary
      reg_row(CFG_PALETTE_MODE, TEMP_BITS'(PAL_GRAY)),
      known_row(1600, 24'hFFFFFF),
      known_row(0, 24'h000000),
      reg_row(CFG_PALETTE_MODE, TEMP_BITS'(PAL_MEDICAL)),
      known_row(32767, 24'hFFFFFF),
      pixel_row(700),
      reg_row(CFG_PALETTE_MODE, TEMP_BITS'(PAL_IRON)),
      known_row(-32768, 24'h000000),
      pixel_row(1599),
      reg_row(CFG_PALETTE_MODE, TEMP_BITS'(PAL_FIRE)),
      known_row(1600, 24'hFFFFFF),
      pixel_row(1000),
      reg_row(CFG_PALETTE_MODE, TEMP_BITS'(PAL_OCEAN)),
      known_row(1600, 24'hFFFFFF),
      pixel_row(1),
      reg_row(CFG_PALETTE_MODE, TEMP_BITS'(PAL_UNUSED)),
      known_row(800, 24'h000000),        // unused palette code is black
      reg_row(CFG_SPARE, 16'h0005),      // out-of-range index is dropped
      known_row(1600, 24'h000000),
      reg_row(CFG_PALETTE_MODE, 16'hFFF8), // upper data bits ignored: vivid
      reg_row(CFG_LOW_TEMP, 16'h7FFF),
      reg_row(CFG_HIGH_TEMP, 16'h8000),
      known_row(32767, 24'h0000FF),      // reversed range pins fraction to 0
      reg_row(CFG_LOW_TEMP, 16'h8000),
      reg_row(CFG_HIGH_TEMP, 16'h7FFF),
      known_row(32767, 24'hFF00FF),      // widest range, both ends
      known_row(-32768, 24'h0000FF),
      pixel_row(0),
      reg_row(CFG_LOW_TEMP, 16'd100),
      reg_row(CFG_HIGH_TEMP, 16'd100),
      known_row(200, 24'h0000FF)         // equal bounds also pin to 0
    };

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        drain();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_pixel(plan[i].value, plan[i].known, plan[i].rgb);
        idle_gap();
      end
    end

    // Random phases. Each one starts from an empty pipe, which also gives
    // the sender a full pause until every owed beat is back. About a quarter
    // of the phases stream back to back with no gaps.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      configure_phase(phase);
      steady = ($urandom_range(0, 3) == 0);
      repeat (BEATS_PER_PHASE) begin
        send_pixel(pick_temperature(), 1'b0, '0);
        if (!steady) idle_gap();
      end
    end

    // Let the pipe empty, then linger so any extra beat gets caught.
    drain();
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 1 ms here).
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tfcm_pkg.sv
rtl/tfcm_front.sv
rtl/tfcm_queue.sv
rtl/tfcm_div.sv
rtl/tfcm_color.sv
rtl/thermal_false_color_mapper.sv
tb/tb.sv
